/* rtl/psue_pkg.sv */
`timescale 1ns / 1ps
// psue_pkg: shared types and codes for the png scanline unfilter and expander
// used by psue_front, psue_recon, psue_outq and the top; depends on nothing else

package psue_pkg;

  // input opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_PAL   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_COLOR_MODE   = 2'd0;
  localparam logic [1:0] CFG_FOUR_BIT     = 2'd1;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_TRANSPARENCY = 2'd3;

  // colour mode codes
  localparam logic [1:0] CM_PALETTE = 2'd0;
  localparam logic [1:0] CM_RGB     = 2'd1;

  // png filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [7:0] OPAQUE = 8'hff;

  // result queue
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;

  typedef enum logic [1:0] {KIND_CLR, KIND_ERR, KIND_PIX, KIND_NIB} psue_kind_t;
  typedef enum logic [1:0] {PIX_PAL, PIX_RGB, PIX_RGBA} psue_pix_t;

  // one item on its way from the front end to the reconstruction stage
  typedef struct packed {
    psue_kind_t  kind;
    logic        clr;     // clear left and upper-left pixels afterwards
    logic [7:0]  data;
    logic [1:0]  lane;
    logic [2:0]  filt;
    logic        use_up;
    logic        last;    // completes a pixel
    psue_pix_t   mode;
    logic [11:0] col0;
    logic [11:0] col1;
    logic        rend0;
    logic        rend1;
    logic        two;     // nibble item with two pixels
  } psue_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic        row_end;
    logic        last_of_run;
  } psue_res_t;

  typedef struct packed {
    logic      v0;
    logic      v1;
    psue_res_t r0;
    psue_res_t r1;
  } psue_push_t;

endpackage

/* rtl/psue_ram.sv */
`timescale 1ns / 1ps
// psue_ram: generic single-write, single-read memory with registered read
// old data is returned when a read and a write hit the same entry; no dependencies

module psue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/psue_front.sv */
`timescale 1ns / 1ps
// psue_front: row position, filter and error tracking at item acceptance
// issues prior-row reads and palette loads; uses psue_pkg

module psue_front #(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic [1:0]                         in_opcode,
  input  logic [7:0]                         in_data_byte,
  input  logic [7:0]                         in_palette_index,
  input  logic [7:0]                         in_palette_red,
  input  logic [7:0]                         in_palette_green,
  input  logic [7:0]                         in_palette_blue,
  input  logic [7:0]                         in_palette_alpha,
  input  logic [1:0]                         color_mode,
  input  logic                               four_bit,
  input  logic [12:0]                        image_width,
  output logic                               item_v,
  output psue_pkg::psue_item_t               item,
  output logic                               prior_re,
  output logic [$clog2(MAX_WIDTH)+1:0]       prior_raddr,
  output logic                               pal_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_waddr,
  output logic [31:0]                        pal_wdata
);

  import psue_pkg::*;

  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int WW  = CLW + 1;
  localparam int PW  = $clog2(PALETTE_ENTRIES);

  logic [CLW-1:0] col_r, col_nxt;
  logic [1:0]     bip_r, bip_nxt;
  logic [2:0]     filt_r, filt_nxt;
  logic           row_start_r, row_start_nxt;
  logic           first_row_r, first_row_nxt;
  logic           err_r, err_nxt;

  logic [WW-1:0]  eff_w, c1, c2;
  logic           rend_a, rend_b;
  logic           filt_ok;
  psue_pix_t      mode;
  logic [2:0]     bpp;
  logic           pix_last;

  always_comb begin
    if (image_width == 13'd0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
  end

  assign c1     = {1'b0, col_r} + WW'(1);
  assign c2     = c1 + WW'(1);
  assign rend_a = (c1 >= eff_w);
  assign rend_b = (c2 >= eff_w);

  assign filt_ok = four_bit ? (in_data_byte == 8'd0) : (in_data_byte <= 8'(FILT_PAETH));

  always_comb begin
    case (color_mode)
      CM_PALETTE: begin
        mode = PIX_PAL;
        bpp  = 3'd1;
      end
      CM_RGB: begin
        mode = PIX_RGB;
        bpp  = 3'd3;
      end
      default: begin
        mode = PIX_RGBA;
        bpp  = 3'd4;
      end
    endcase
  end

  assign pix_last    = ({1'b0, bip_r} + 3'd1) >= bpp;
  assign prior_raddr = {col_r, bip_r};
  assign pal_waddr   = PW'(in_palette_index);
  assign pal_wdata   = {in_palette_alpha, in_palette_blue, in_palette_green, in_palette_red};

  always_comb begin
    col_nxt       = col_r;
    bip_nxt       = bip_r;
    filt_nxt      = filt_r;
    row_start_nxt = row_start_r;
    first_row_nxt = first_row_r;
    err_nxt       = err_r;
    item_v        = 1'b0;
    prior_re      = 1'b0;
    pal_we        = 1'b0;
    item          = '0;
    item.kind     = KIND_CLR;
    item.mode     = mode;
    item.data     = in_data_byte;
    item.lane     = bip_r;
    item.filt     = filt_r;
    item.use_up   = !first_row_r;
    item.col0     = 12'(col_r);
    item.col1     = 12'(c1);
    if (accept) begin
      case (in_opcode)
        OP_PAL: begin
          pal_we = (32'(in_palette_index) < PALETTE_ENTRIES);
        end
        OP_START: begin
          col_nxt       = '0;
          bip_nxt       = 2'd0;
          row_start_nxt = 1'b1;
          first_row_nxt = 1'b1;
          err_nxt       = 1'b0;
          filt_nxt      = FILT_NONE;
          item_v        = 1'b1;
          item.kind     = KIND_CLR;
          item.clr      = 1'b1;
        end
        OP_BYTE: begin
          if (!err_r) begin
            item_v = 1'b1;
            if (row_start_r) begin
              if (!filt_ok) begin
                err_nxt   = 1'b1;
                item.kind = KIND_ERR;
              end else begin
                filt_nxt      = in_data_byte[2:0];
                col_nxt       = '0;
                bip_nxt       = 2'd0;
                row_start_nxt = 1'b0;
                item.kind     = KIND_CLR;
                item.clr      = 1'b1;
              end
            end else if (four_bit) begin
              item.kind  = KIND_NIB;
              item.rend0 = rend_a;
              if (rend_a) begin
                col_nxt       = '0;
                bip_nxt       = 2'd0;
                row_start_nxt = 1'b1;
                first_row_nxt = 1'b0;
                item.clr      = 1'b1;
              end else begin
                item.two   = 1'b1;
                item.rend1 = rend_b;
                if (rend_b) begin
                  col_nxt       = '0;
                  bip_nxt       = 2'd0;
                  row_start_nxt = 1'b1;
                  first_row_nxt = 1'b0;
                  item.clr      = 1'b1;
                end else begin
                  col_nxt = CLW'(c2);
                end
              end
            end else begin
              item.kind = KIND_PIX;
              item.last = pix_last;
              prior_re  = 1'b1;
              if (pix_last) begin
                bip_nxt    = 2'd0;
                item.rend0 = rend_a;
                if (rend_a) begin
                  col_nxt       = '0;
                  row_start_nxt = 1'b1;
                  first_row_nxt = 1'b0;
                  item.clr      = 1'b1;
                end else begin
                  col_nxt = CLW'(c1);
                end
              end else begin
                bip_nxt = bip_r + 2'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      bip_r       <= 2'd0;
      filt_r      <= FILT_NONE;
      row_start_r <= 1'b1;
      first_row_r <= 1'b1;
      err_r       <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      bip_r       <= bip_nxt;
      filt_r      <= filt_nxt;
      row_start_r <= row_start_nxt;
      first_row_r <= first_row_nxt;
      err_r       <= err_nxt;
    end
  end

  // the error flag can only be raised by a bad filter byte at a row start
  a_err_from_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(err_r) |-> $past(row_start_r) && $past(accept) && ($past(in_opcode) == OP_BYTE))
    else $error("error flag raised away from a row start");

endmodule

/* rtl/psue_recon.sv */
`timescale 1ns / 1ps
// psue_recon: filter reconstruction against the prior row and pixel expansion
// two stages after the front end; drives the prior-row write and palette reads; uses psue_pkg

module psue_recon #(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               item_v,
  input  psue_pkg::psue_item_t               item,
  input  logic [$clog2(MAX_WIDTH)+1:0]       slot,
  input  logic [7:0]                         prior_rdata,
  input  logic                               transparency,
  output logic                               prior_we,
  output logic [$clog2(MAX_WIDTH)+1:0]       prior_waddr,
  output logic [7:0]                         prior_wdata,
  output logic                               pal_re,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_raddr_a,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_raddr_b,
  input  logic [31:0]                        pal_rdata_a,
  input  logic [31:0]                        pal_rdata_b,
  output psue_pkg::psue_push_t               push,
  output logic [1:0]                         inflight
);

  import psue_pkg::*;

  localparam int SW = $clog2(MAX_WIDTH) + 2;
  localparam int PW = $clog2(PALETTE_ENTRIES);

  // reconstruction stage
  logic           b_v_r;
  psue_item_t     b_item_r;
  logic [SW-1:0]  b_slot_r;
  logic [3:0][7:0] left_r, left_nxt, left_m;
  logic [3:0][7:0] upper_r, upper_nxt, upper_m;

  // result stage
  logic           c_v_r, c_v_nxt;
  psue_item_t     c_item_r;
  logic [31:0]    c_rgba_r;
  logic           c_ok_r, pal_ok;

  logic [7:0]     up, a, c, pred, val;
  logic [8:0]     avg_sum;
  logic signed [9:0] sa, sb, sc, da, db, dc;
  logic [9:0]     pa, pb, pc;
  logic [31:0]    pal_a, pal_b, rgba0;

  always_comb begin
    up      = b_item_r.use_up ? prior_rdata : 8'd0;
    a       = left_r[b_item_r.lane];
    c       = upper_r[b_item_r.lane];
    avg_sum = {1'b0, a} + {1'b0, up};
    sa      = signed'({2'b00, a});
    sb      = signed'({2'b00, up});
    sc      = signed'({2'b00, c});
    // distances of a + b - c to a, b and c
    da      = sb - sc;
    db      = sa - sc;
    dc      = sa + sb - sc - sc;
    pa      = (da < 0) ? unsigned'(-da) : unsigned'(da);
    pb      = (db < 0) ? unsigned'(-db) : unsigned'(db);
    pc      = (dc < 0) ? unsigned'(-dc) : unsigned'(dc);
    case (b_item_r.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = up;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    val = b_item_r.data + pred;

    left_m  = left_r;
    upper_m = upper_r;
    left_m[b_item_r.lane]  = val;
    upper_m[b_item_r.lane] = up;

    left_nxt  = left_r;
    upper_nxt = upper_r;
    if (b_v_r) begin
      if (b_item_r.clr) begin
        left_nxt  = '0;
        upper_nxt = '0;
      end else if (b_item_r.kind == KIND_PIX) begin
        left_nxt  = left_m;
        upper_nxt = upper_m;
      end
    end
  end

  assign prior_we    = b_v_r && (b_item_r.kind == KIND_PIX);
  assign prior_waddr = b_slot_r;
  assign prior_wdata = val;

  // palette lookups all leave from this stage, so a load behind them reads as later
  assign pal_re      = b_v_r;
  assign pal_raddr_a = (b_item_r.kind == KIND_NIB) ? PW'(b_item_r.data[7:4]) : PW'(left_m[0]);
  assign pal_raddr_b = PW'(b_item_r.data[3:0]);
  assign pal_ok      = (b_item_r.kind == KIND_NIB) || (32'(left_m[0]) < PALETTE_ENTRIES);

  assign c_v_nxt = b_v_r && ((b_item_r.kind == KIND_ERR) || (b_item_r.kind == KIND_NIB) ||
                             ((b_item_r.kind == KIND_PIX) && b_item_r.last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      left_r  <= '0;
      upper_r <= '0;
    end else begin
      b_v_r   <= item_v;
      c_v_r   <= c_v_nxt;
      left_r  <= left_nxt;
      upper_r <= upper_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_item_r <= item;
    b_slot_r <= slot;
    c_item_r <= b_item_r;
    c_rgba_r <= left_m;
    c_ok_r   <= pal_ok;
  end

  always_comb begin
    pal_a = c_ok_r ? pal_rdata_a : 32'd0;
    pal_b = pal_rdata_b;
    if (!transparency) begin
      pal_a = {OPAQUE, pal_a[23:0]};
      pal_b = {OPAQUE, pal_b[23:0]};
    end
    case (c_item_r.mode)
      PIX_PAL: rgba0 = pal_a;
      PIX_RGB: rgba0 = {OPAQUE, c_rgba_r[23:0]};
      default: rgba0 = c_rgba_r;
    endcase

    push    = '0;
    push.v0 = c_v_r;
    case (c_item_r.kind)
      KIND_ERR: begin
        push.r0.status      = 1'b1;
        push.r0.last_of_run = 1'b1;
      end
      KIND_PIX: begin
        {push.r0.alpha, push.r0.blue, push.r0.green, push.r0.red} = rgba0;
        push.r0.column      = c_item_r.col0;
        push.r0.row_end     = c_item_r.rend0;
        push.r0.last_of_run = 1'b1;
      end
      KIND_NIB: begin
        {push.r0.alpha, push.r0.blue, push.r0.green, push.r0.red} = pal_a;
        push.r0.column      = c_item_r.col0;
        push.r0.row_end     = c_item_r.rend0;
        push.r0.last_of_run = !c_item_r.two;
        push.v1             = c_v_r && c_item_r.two;
        {push.r1.alpha, push.r1.blue, push.r1.green, push.r1.red} = pal_b;
        push.r1.column      = c_item_r.col1;
        push.r1.row_end     = c_item_r.rend1;
        push.r1.last_of_run = 1'b1;
      end
      default: ;
    endcase
  end

  assign inflight = {1'b0, b_v_r} + {1'b0, c_v_r};

endmodule

/* rtl/psue_outq.sv */
`timescale 1ns / 1ps
// psue_outq: pipeline-to-result-channel queue; uses psue_pkg
// takes one or two results a cycle, delivers one unless stalled

module psue_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psue_pkg::psue_push_t push,
  input  logic                 out_stall,
  output logic                 out_valid,
  output psue_pkg::psue_res_t  out_res,
  output logic [3:0]           count
);

  import psue_pkg::*;

  psue_res_t         q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_res   = q_mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign count     = 4'(count_r);

  assign count_nxt = count_r + (Q_AW + 1)'(push.v0) + (Q_AW + 1)'(push.v1)
                     - (Q_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q_mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      q_mem_r[wr_ptr_r + Q_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_AW'(push.v0) + Q_AW'(push.v1);
      rd_ptr_r <= rd_ptr_r + Q_AW'(pop);
      count_r  <= count_nxt;
    end
  end

  // a second result always comes with a first
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0)
    else $error("second result pushed without the first");

endmodule

/* rtl/png_scanline_unfilter_expand_top.sv */
`timescale 1ns / 1ps
// png_scanline_unfilter_expand_top: png scanline unfilter and rgba pixel expander
// depends on psue_pkg, psue_ram, psue_front, psue_recon and psue_outq
//
//   port group  direction  flow control      carries
//   in_*        input      in_valid/in_stall  opcode, stream byte, palette load
//   out_*       output     out_valid/out_stall one rgba pixel or an error mark
//   cfg_*       input      cfg_we             register index and write data
//
// one item is taken per cycle while in_stall is low; a 4-bit palette byte gives
// two results, so in that mode the single-result output port throttles the input.
// a result passes the reconstruction stage, the result stage and the queue. the
// prior row lives in a registered-read ram, read at acceptance and written
// in the next cycle. reset clears control state and the left pixels; the prior-row
// store and the palette are not cleared and need no clearing pass.
// in_stall rises only when the eight-entry result queue could overflow.

module png_scanline_unfilter_expand_top #(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_palette_index,
  input  logic [7:0]  in_palette_red,
  input  logic [7:0]  in_palette_green,
  input  logic [7:0]  in_palette_blue,
  input  logic [7:0]  in_palette_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [11:0] out_column,
  output logic        out_row_end,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  import psue_pkg::*;

  localparam int SW = $clog2(MAX_WIDTH) + 2;
  localparam int PW = $clog2(PALETTE_ENTRIES);

  logic [1:0]    color_mode_r;
  logic          four_bit_r;
  logic [12:0]   image_width_r;
  logic          transparency_r;

  logic          accept;
  logic          item_v;
  psue_item_t    item;
  logic          pr_re, pr_we;
  logic [SW-1:0] pr_raddr, pr_waddr;
  logic [7:0]    pr_rdata, pr_wdata;
  logic          pal_we, pal_re;
  logic [PW-1:0] pal_waddr, pal_raddr_a, pal_raddr_b;
  logic [31:0]   pal_wdata, pal_rdata_a, pal_rdata_b;
  psue_push_t    push;
  psue_res_t     out_res;
  logic [1:0]    inflight;
  logic [3:0]    q_count;
  logic [4:0]    need;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r   <= CM_PALETTE;
      four_bit_r     <= 1'b0;
      image_width_r  <= 13'd1;
      transparency_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MODE:   color_mode_r   <= cfg_wdata[1:0];
        CFG_FOUR_BIT:     four_bit_r     <= cfg_wdata[0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        CFG_TRANSPARENCY: transparency_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // every item in flight may still bring two results
  assign need     = 5'(q_count) + 5'({inflight, 1'b0}) + 5'd2;
  assign in_stall = (need > 5'(Q_DEPTH));
  assign accept   = in_valid && !in_stall;

  psue_front #(
    .MAX_WIDTH       (MAX_WIDTH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .in_palette_index (in_palette_index),
    .in_palette_red   (in_palette_red),
    .in_palette_green (in_palette_green),
    .in_palette_blue  (in_palette_blue),
    .in_palette_alpha (in_palette_alpha),
    .color_mode       (color_mode_r),
    .four_bit         (four_bit_r),
    .image_width      (image_width_r),
    .item_v           (item_v),
    .item             (item),
    .prior_re         (pr_re),
    .prior_raddr      (pr_raddr),
    .pal_we           (pal_we),
    .pal_waddr        (pal_waddr),
    .pal_wdata        (pal_wdata)
  );

  psue_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH * 4)
  ) u_prior_row (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .re    (pr_re),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  // two copies of the palette give the two nibble lookups of one item
  psue_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette_a (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr_a),
    .rdata (pal_rdata_a)
  );

  psue_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette_b (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr_b),
    .rdata (pal_rdata_b)
  );

  psue_recon #(
    .MAX_WIDTH       (MAX_WIDTH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_recon (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_v       (item_v),
    .item         (item),
    .slot         (pr_raddr),
    .prior_rdata  (pr_rdata),
    .transparency (transparency_r),
    .prior_we     (pr_we),
    .prior_waddr  (pr_waddr),
    .prior_wdata  (pr_wdata),
    .pal_re       (pal_re),
    .pal_raddr_a  (pal_raddr_a),
    .pal_raddr_b  (pal_raddr_b),
    .pal_rdata_a  (pal_rdata_a),
    .pal_rdata_b  (pal_rdata_b),
    .push         (push),
    .inflight     (inflight)
  );

  psue_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .count     (q_count)
  );

  assign out_status      = out_res.status;
  assign out_red         = out_res.red;
  assign out_green       = out_res.green;
  assign out_blue        = out_res.blue;
  assign out_alpha       = out_res.alpha;
  assign out_column      = out_res.column;
  assign out_row_end     = out_res.row_end;
  assign out_last_of_run = out_res.last_of_run;

  // a byte's slot is never read again before its write-back has landed
  a_no_prior_collision: assert property (@(posedge clk) disable iff (!rst_n)
    pr_we && pr_re |-> pr_waddr != pr_raddr)
    else $error("prior-row read and write hit the same slot");

  // results in flight never exceed the queue space
  a_queue_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (5'(q_count) + 5'({inflight, 1'b0})) <= 5'(Q_DEPTH))
    else $error("result queue space over-committed");

endmodule
